### hdl/assert_macros.svh
// Assertion macros shared by the shell rotation RTL.
// Expects a clock named clk and an active-low asynchronous reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

### hdl/csr_pkg.sv
// Types and constants of the Cartesian shell rotation block.
// No dependencies; used by csr_merge and cartesian_shell_rotation.
package csr_pkg;

	// Shell kind carried with each item
	typedef enum logic [1:0] {
		SHELL_S = 2'd0,
		SHELL_P = 2'd1,
		SHELL_D = 2'd2
	} shell_t;

	// Control travelling alongside the lane results
	typedef struct packed {
		logic   vld;
		shell_t cmd;
	} ctl_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 2'd2;

	localparam int unsigned NUM_ROWS = 3;
	localparam int unsigned NUM_COEF = 6;

	// Coefficient slot of symmetric matrix element D[k][j]
	localparam int unsigned DMAP [NUM_ROWS][NUM_ROWS] = '{
		'{0, 1, 2},
		'{1, 3, 4},
		'{2, 4, 5}
	};

	// Row and column of each upper-triangle result slot
	localparam int unsigned OUT_I [NUM_COEF] = '{0, 0, 0, 1, 1, 2};
	localparam int unsigned OUT_J [NUM_COEF] = '{0, 1, 2, 1, 2, 2};

endpackage

### hdl/csr_lane.sv
// One lane: a three-term signed dot product with rounding, two register stages.
// No package dependencies.
module csr_lane #(
	parameter int A_W  = 18,
	parameter int B_W  = 32,
	parameter int FRAC = 16
) (
	input  logic                           clk,
	input  logic signed [A_W-1:0]          a [3],
	input  logic signed [B_W-1:0]          b [3],
	output logic signed [A_W+B_W+2-FRAC:0] res
);
	localparam int P_W   = A_W + B_W;
	localparam int SUM_W = P_W + 3;
	localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (FRAC - 1);

	logic signed [P_W-1:0] prod_s1 [3];
	logic [SUM_W-1:0]      sum;
	logic signed [SUM_W-1-FRAC:0] res_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s1[k] <= a[k] * b[k];
		end
	end

	// sign-extend, add, round half up
	always_comb begin
		sum = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[2]) + RND;
	end

	always_ff @(posedge clk) begin
		res_s2 <= sum[SUM_W-1:FRAC];
	end

	assign res = res_s2;

endmodule

### hdl/csr_merge.sv
// Merge stage: saturates lane results and selects by shell kind into the output register.
// Depends on csr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module csr_merge #(
	parameter int COEF_W = 32,
	parameter int T_W    = 37,
	parameter int U_W    = 42
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  csr_pkg::ctl_t            ctl,
	input  logic signed [COEF_W-1:0] c0,
	input  logic signed [T_W-1:0]    tcol [3],
	input  logic signed [U_W-1:0]    u [6],
	output logic                     done,
	output logic signed [COEF_W-1:0] res [6]
);
	import csr_pkg::*;

	localparam logic [COEF_W-1:0] SAT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] SAT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	logic                     done_q;
	logic signed [COEF_W-1:0] res_q [NUM_COEF];
	logic signed [COEF_W-1:0] res_d [NUM_COEF];

	function automatic logic [COEF_W-1:0] sat_t(input logic [T_W-1:0] x);
		logic [T_W-COEF_W:0] hi_bits;
		hi_bits = x[T_W-1:COEF_W-1];
		if (&hi_bits || ~|hi_bits)
			return x[COEF_W-1:0];
		return x[T_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

	function automatic logic [COEF_W-1:0] sat_u(input logic [U_W-1:0] x);
		logic [U_W-COEF_W:0] hi_bits;
		hi_bits = x[U_W-1:COEF_W-1];
		if (&hi_bits || ~|hi_bits)
			return x[COEF_W-1:0];
		return x[U_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

	always_comb begin
		for (int k = 0; k < NUM_COEF; k++) begin
			res_d[k] = '0;
		end
		unique case (ctl.cmd)
			SHELL_S: begin
				res_d[0] = c0;
			end
			SHELL_P: begin
				for (int i = 0; i < NUM_ROWS; i++) begin
					res_d[i] = sat_t(tcol[i]);
				end
			end
			SHELL_D: begin
				for (int k = 0; k < NUM_COEF; k++) begin
					res_d[k] = sat_u(u[k]);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done = done_q;
	assign res  = res_q;

	`ASSERT_CLK(a_unused_slots_zero, ctl.cmd != SHELL_D |=> res_q[3] == '0 && res_q[4] == '0 && res_q[5] == '0, "unused result slots not zero")

endmodule

### hdl/cartesian_shell_rotation.sv
// Top level of the Cartesian shell rotation block: config registers, lanes, merge.
// Depends on csr_pkg, csr_lane, csr_merge and assert_macros.svh.
`include "assert_macros.svh"
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  config    | cfg_we               | cfg_idx, cfg_wdata (one rotation row)
//  item in   | start & !busy        | cmd, coef_0 .. coef_5
//  result    | done (one-cycle)     | out_0 .. out_5
//
//  One item per clock; every transfer gives one result, marked by done.
//  Pipeline: two lane banks, each a multiply register and a sum/round register,
//  then the saturate/select register of the merge stage.
//  busy is held low: the pipeline has no stall and the receiver takes every result.
//  Reset clears the valid pipeline and loads the identity rotation.
//
module cartesian_shell_rotation #(
	parameter int COEF_WIDTH    = 32,
	parameter int ROT_FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [csr_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [3*(ROT_FRAC_BITS+2)-1:0]       cfg_wdata,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           cmd,
	input  logic signed [COEF_WIDTH-1:0]         coef_0,
	input  logic signed [COEF_WIDTH-1:0]         coef_1,
	input  logic signed [COEF_WIDTH-1:0]         coef_2,
	input  logic signed [COEF_WIDTH-1:0]         coef_3,
	input  logic signed [COEF_WIDTH-1:0]         coef_4,
	input  logic signed [COEF_WIDTH-1:0]         coef_5,
	output logic                                 done,
	output logic signed [COEF_WIDTH-1:0]         out_0,
	output logic signed [COEF_WIDTH-1:0]         out_1,
	output logic signed [COEF_WIDTH-1:0]         out_2,
	output logic signed [COEF_WIDTH-1:0]         out_3,
	output logic signed [COEF_WIDTH-1:0]         out_4,
	output logic signed [COEF_WIDTH-1:0]         out_5
);
	import csr_pkg::*;

	// Rotation entry width and the widths that grow through the two lane banks
	localparam int RE    = ROT_FRAC_BITS + 2;
	localparam int ROW_W = 3 * RE;
	localparam int T_W   = RE + COEF_WIDTH + 3 - ROT_FRAC_BITS;
	localparam int U_W   = T_W + RE + 3 - ROT_FRAC_BITS;

	logic [ROW_W-1:0]            rot_q [NUM_ROWS];
	logic signed [RE-1:0]        rent  [NUM_ROWS][NUM_ROWS];
	logic signed [COEF_WIDTH-1:0] cin  [NUM_COEF];

	// Control and the pass-through payload that runs beside the lanes
	logic   v_s1, v_s2, v_s3, v_s4;
	shell_t cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic signed [COEF_WIDTH-1:0] c0_s1, c0_s2, c0_s3, c0_s4;
	logic signed [T_W-1:0] tcol_s3 [NUM_ROWS];
	logic signed [T_W-1:0] tcol_s4 [NUM_ROWS];

	// Lane outputs: T = R*D from the first bank, upper triangle from the second
	logic signed [T_W-1:0] t_s2 [NUM_ROWS][NUM_ROWS];
	logic signed [U_W-1:0] u_s4 [NUM_COEF];

	logic signed [COEF_WIDTH-1:0] res [NUM_COEF];
	ctl_t ctl_s4;

	// Every start is a transfer; nothing in the pipeline ever stalls.
	assign busy = 1'b0;

	// Rotation rows: reset to identity, write any row while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				rot_q[r] <= ROW_W'(1) << (ROT_FRAC_BITS + r * RE);
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ROT_ROW0: rot_q[0] <= cfg_wdata;
				REG_ROT_ROW1: rot_q[1] <= cfg_wdata;
				REG_ROT_ROW2: rot_q[2] <= cfg_wdata;
				default: ;   // drop writes beyond the register list
			endcase
		end
	end

	// Unpack signed Q1.16 entries, column 0 in the low bits
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int c = 0; c < NUM_ROWS; c++) begin
				rent[r][c] = rot_q[r][c*RE +: RE];
			end
		end
	end

	assign cin[0] = coef_0;
	assign cin[1] = coef_1;
	assign cin[2] = coef_2;
	assign cin[3] = coef_3;
	assign cin[4] = coef_4;
	assign cin[5] = coef_5;

	// Valid and shell kind advance one stage a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			cmd_s1 <= SHELL_S;
			cmd_s2 <= SHELL_S;
			cmd_s3 <= SHELL_S;
			cmd_s4 <= SHELL_S;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			cmd_s1 <= shell_t'(cmd);
			cmd_s2 <= cmd_s1;
			cmd_s3 <= cmd_s2;
			cmd_s4 <= cmd_s3;
		end
	end

	// The s coefficient and column 0 of T (which is R*(x,y,z), the p result)
	// are delayed to line up with the second bank.
	always_ff @(posedge clk) begin
		c0_s1 <= coef_0;
		c0_s2 <= c0_s1;
		c0_s3 <= c0_s2;
		c0_s4 <= c0_s3;
		for (int i = 0; i < NUM_ROWS; i++) begin
			tcol_s3[i] <= t_s2[i][0];
			tcol_s4[i] <= tcol_s3[i];
		end
	end

	// First bank: nine lanes, T[i][j] = rnd(sum_k R[i][k] * D[k][j])
	for (genvar i = 0; i < NUM_ROWS; i++) begin : g_row
		for (genvar j = 0; j < NUM_ROWS; j++) begin : g_col
			logic signed [COEF_WIDTH-1:0] dsel [3];
			for (genvar k = 0; k < 3; k++) begin : g_term
				assign dsel[k] = cin[DMAP[k][j]];
			end
			csr_lane #(
				.A_W  (RE),
				.B_W  (COEF_WIDTH),
				.FRAC (ROT_FRAC_BITS)
			) u_lane_t (
				.clk (clk),
				.a   (rent[i]),
				.b   (dsel),
				.res (t_s2[i][j])
			);
		end
	end

	// Second bank: six lanes, upper triangle of T * R^T
	for (genvar k = 0; k < NUM_COEF; k++) begin : g_out
		csr_lane #(
			.A_W  (T_W),
			.B_W  (RE),
			.FRAC (ROT_FRAC_BITS)
		) u_lane_u (
			.clk (clk),
			.a   (t_s2[OUT_I[k]]),
			.b   (rent[OUT_J[k]]),
			.res (u_s4[k])
		);
	end

	assign ctl_s4 = '{vld: v_s4, cmd: cmd_s4};

	// Saturate, select by shell kind and register the result
	csr_merge #(
		.COEF_W (COEF_WIDTH),
		.T_W    (T_W),
		.U_W    (U_W)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_s4),
		.c0     (c0_s4),
		.tcol   (tcol_s4),
		.u      (u_s4),
		.done   (done),
		.res    (res)
	);

	assign out_0 = res[0];
	assign out_1 = res[1];
	assign out_2 = res[2];
	assign out_3 = res[3];
	assign out_4 = res[4];
	assign out_5 = res[5];

	`ASSERT_CLK(a_fixed_latency, start |=> ##4 done, "result strobe missing five cycles after a transfer")
	`ASSERT_CLK(a_no_spurious_done, done |-> $past(start, 5), "result strobe without a transfer")
	`ASSERT_NEVER(a_never_busy, busy, "busy raised")

endmodule
